@@ sv/mtgd_pkg.sv @@
// ----------------------------------------------------------------------------
// mtgd_pkg
// Types and constants shared by the multibyte text glyph decoder.
// ----------------------------------------------------------------------------
package mtgd_pkg;

    localparam int ADDR_W = 32;
    localparam int DX_W   = 13;

    // language modes
    localparam logic [1:0] MODE_ASCII = 2'd0;
    localparam logic [1:0] MODE_SJIS  = 2'd1;
    localparam logic [1:0] MODE_EUCJP = 2'd2;
    localparam logic [1:0] MODE_GB    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_LANG_MODE  = 2'd0;
    localparam logic [1:0] REG_ASCII_BASE = 2'd1;
    localparam logic [1:0] REG_JP_BASE    = 2'd2;
    localparam logic [1:0] REG_CN_BASE    = 2'd3;

    // command codes
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // glyph kinds
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_LEFT   = 2'd1;
    localparam logic [1:0] KIND_RIGHT  = 2'd2;
    localparam logic [1:0] KIND_MIRROR = 2'd3;

    // byte ranges
    localparam logic [7:0] SJ_LEAD1_LO  = 8'h81;
    localparam logic [7:0] SJ_LEAD1_HI  = 8'h9f;
    localparam logic [7:0] SJ_LEAD2_LO  = 8'he0;
    localparam logic [7:0] SJ_LEAD2_HI  = 8'hfc;
    localparam logic [7:0] SJ_TRAIL1_LO = 8'h40;
    localparam logic [7:0] SJ_TRAIL1_HI = 8'h7e;
    localparam logic [7:0] SJ_TRAIL2_LO = 8'h80;
    localparam logic [7:0] SJ_TRAIL2_HI = 8'h9e;
    localparam logic [7:0] SJ_TRAIL3_LO = 8'h9f;
    localparam logic [7:0] EUC_LEAD_LO  = 8'h81;
    localparam logic [7:0] EUC_LEAD_HI  = 8'hfe;
    localparam logic [7:0] ROW_LO       = 8'ha1;
    localparam logic [7:0] ROW_HI       = 8'hfe;

    localparam int ROW_CELLS     = 94;
    localparam int SJ_ROW_OFFSET = 62;
    localparam int SJ_TRAIL2_ADD = 63;
    localparam logic [ADDR_W-1:0] JP_FULL_OFFSET = ADDR_W'(256 * 16);
    localparam logic [ADDR_W-1:0] HALF_STEP      = ADDR_W'(16);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DX_W-1:0]   dx;
        logic [1:0]        kind;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;   // results produced: 0, 1 or 2
        t_result    res0;
        t_result    res1;
        logic [7:0] lead;  // next pending lead byte
    } t_dec;

endpackage

@@ sv/mtgd_decode.sv @@
// ----------------------------------------------------------------------------
// mtgd_decode
// Single-pass byte decode: lead detection, row/cell index, font address,
// draw columns and next cursor/lead state.
// ----------------------------------------------------------------------------
module mtgd_decode
    import mtgd_pkg::*;
#(
    parameter int COLUMN_BITS = 12
) (
    input  logic                   i_cmd,
    input  logic [11:0]            i_start_x,
    input  logic [7:0]             i_byte,
    input  logic [1:0]             i_mode,
    input  logic [ADDR_W-1:0]      i_ascii_base,
    input  logic [ADDR_W-1:0]      i_jp_base,
    input  logic [ADDR_W-1:0]      i_cn_base,
    input  logic [7:0]             i_lead,
    input  logic [COLUMN_BITS-1:0] i_cursor,
    output t_dec                   o_dec,
    output logic [COLUMN_BITS-1:0] o_cursor
);

    localparam int XW = (COLUMN_BITS > DX_W) ? COLUMN_BITS : DX_W;

    logic [XW-1:0]        cur_ext;
    logic [XW-1:0]        cur_m8;
    logic [DX_W-1:0]      dx_cur;
    logic [DX_W-1:0]      dx_m8;
    logic                 is_lead;
    logic [ADDR_W-1:0]    single_base;
    logic [ADDR_W-1:0]    single_addr;
    logic signed [15:0]   lb_s;
    logic signed [15:0]   b_s;
    logic signed [15:0]   k;
    logic signed [15:0]   t;
    logic signed [15:0]   idx;
    logic [ADDR_W-1:0]    idx_off;
    logic [ADDR_W-1:0]    jp_addr;
    logic [ADDR_W-1:0]    cn_addr;
    t_result              single_res;

    assign cur_ext = XW'(i_cursor);
    assign cur_m8  = cur_ext - XW'(8);
    assign dx_cur  = cur_ext[DX_W-1:0];
    assign dx_m8   = cur_m8[DX_W-1:0];

    always_comb begin
        unique case (i_mode)
            MODE_SJIS:  is_lead = (i_byte >= SJ_LEAD1_LO && i_byte <= SJ_LEAD1_HI) ||
                                  (i_byte >= SJ_LEAD2_LO && i_byte <= SJ_LEAD2_HI);
            MODE_EUCJP: is_lead = i_byte >= EUC_LEAD_LO && i_byte <= EUC_LEAD_HI;
            MODE_GB:    is_lead = i_byte >= ROW_LO && i_byte <= ROW_HI;
            default:    is_lead = 1'b0;
        endcase
    end

    assign single_base = (i_mode == MODE_SJIS || i_mode == MODE_EUCJP) ? i_jp_base
                                                                       : i_ascii_base;
    assign single_addr = single_base + {20'd0, i_byte, 4'd0};

    assign single_res.addr = single_addr;
    assign single_res.dx   = dx_cur;
    assign single_res.kind = KIND_SINGLE;
    assign single_res.last = 1'b1;

    assign lb_s = signed'({8'd0, i_lead});
    assign b_s  = signed'({8'd0, i_byte});

    always_comb begin
        if (i_mode == MODE_SJIS) begin
            if (i_lead >= SJ_LEAD1_LO && i_lead <= SJ_LEAD1_HI) begin
                k = (lb_s - signed'({8'd0, SJ_LEAD1_LO})) * 16'sd2;
            end else begin
                k = (lb_s - signed'({8'd0, SJ_LEAD2_LO})) * 16'sd2 + 16'(SJ_ROW_OFFSET);
            end
            if (i_byte >= SJ_TRAIL1_LO && i_byte <= SJ_TRAIL1_HI) begin
                t = b_s - signed'({8'd0, SJ_TRAIL1_LO});
            end else if (i_byte >= SJ_TRAIL2_LO && i_byte <= SJ_TRAIL2_HI) begin
                t = b_s - signed'({8'd0, SJ_TRAIL2_LO}) + 16'(SJ_TRAIL2_ADD);
            end else begin
                t = b_s - signed'({8'd0, SJ_TRAIL3_LO});
                k = k + 16'sd1;
            end
        end else begin
            k = lb_s - signed'({8'd0, ROW_LO});
            t = b_s - signed'({8'd0, ROW_LO});
        end
    end

    assign idx     = k * 16'(ROW_CELLS) + t;
    assign idx_off = {{(ADDR_W-21){idx[15]}}, idx, 5'd0};
    assign jp_addr = i_jp_base + JP_FULL_OFFSET + idx_off;
    assign cn_addr = i_cn_base + idx_off;

    always_comb begin
        o_dec.num  = 2'd0;
        o_dec.res0 = single_res;
        o_dec.res1 = single_res;
        o_dec.lead = i_lead;
        o_cursor   = COLUMN_BITS'(i_cursor + COLUMN_BITS'(8));
        if (i_cmd == CMD_BEGIN) begin
            o_cursor = COLUMN_BITS'(i_start_x);
        end else if (i_mode == MODE_ASCII) begin
            o_dec.num = 2'd1;
        end else if (i_lead == 8'd0) begin
            if (is_lead) begin
                o_dec.lead = i_byte;
            end else begin
                o_dec.num = 2'd1;
            end
        end else begin
            o_dec.lead = 8'd0;
            if (i_mode == MODE_GB) begin
                o_dec.num       = 2'd1;
                o_dec.res0.addr = cn_addr;
                o_dec.res0.dx   = dx_m8;
                o_dec.res0.kind = KIND_MIRROR;
                o_dec.res0.last = 1'b1;
            end else begin
                o_dec.num       = 2'd2;
                o_dec.res0.addr = jp_addr;
                o_dec.res0.dx   = dx_m8;
                o_dec.res0.kind = KIND_LEFT;
                o_dec.res0.last = 1'b0;
                o_dec.res1.addr = jp_addr + HALF_STEP;
                o_dec.res1.dx   = dx_cur;
                o_dec.res1.kind = KIND_RIGHT;
                o_dec.res1.last = 1'b1;
            end
        end
    end

endmodule

@@ sv/multibyte_text_glyph_decoder_core.sv @@
// ----------------------------------------------------------------------------
// multibyte_text_glyph_decoder_core
// A byte is held in the input register, decoded, and written to the result
// queue, whose head drives the output. Throughput: one byte per cycle while
// the result queue holds at most two entries; a Shift-JIS/EUC-JP trail byte
// yields two commands (4-entry result queue).
// Reset (synchronous, active low): mode and bases 0, no pending lead, cursor 0.
// ----------------------------------------------------------------------------
module multibyte_text_glyph_decoder_core
    import mtgd_pkg::*;
#(
    parameter int COLUMN_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [11:0] start_x, [19:12] char_byte, [23:20] zero
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] glyph_addr, [44:32] draw_x, [47:45] zero
    output logic [1:0]  m_axis_tuser,   // glyph_kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    logic [1:0]             r_mode;
    logic [ADDR_W-1:0]      r_ascii_base;
    logic [ADDR_W-1:0]      r_jp_base;
    logic [ADDR_W-1:0]      r_cn_base;
    logic [7:0]             r_lead;
    logic [COLUMN_BITS-1:0] r_cursor;

    logic                   r_in_vld;
    logic                   r_in_cmd;
    logic [11:0]            r_in_sx;
    logic [7:0]             r_in_byte;

    t_result                r_q [QD];
    logic [PW-1:0]          r_wr_ptr;
    logic [PW-1:0]          r_rd_ptr;
    logic [PW:0]            r_cnt;
    logic [PW:0]            n_cnt;

    t_dec                   dec;
    logic [COLUMN_BITS-1:0] dec_cursor;
    logic                   proc;
    logic                   pop;
    logic [PW:0]            wr_num;
    t_result                head;

    assign o_cfg_ready = 1'b1;

    assign proc          = r_in_vld && (r_cnt <= (PW+1)'(QD - 2));
    assign s_axis_tready = !r_in_vld || proc;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign wr_num        = proc ? (PW+1)'(dec.num) : '0;
    assign n_cnt         = r_cnt + wr_num - (PW+1)'(pop);

    mtgd_decode #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_decode (
        .i_cmd        (r_in_cmd),
        .i_start_x    (r_in_sx),
        .i_byte       (r_in_byte),
        .i_mode       (r_mode),
        .i_ascii_base (r_ascii_base),
        .i_jp_base    (r_jp_base),
        .i_cn_base    (r_cn_base),
        .i_lead       (r_lead),
        .i_cursor     (r_cursor),
        .o_dec        (dec),
        .o_cursor     (dec_cursor)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_ASCII;
            r_ascii_base <= '0;
            r_jp_base    <= '0;
            r_cn_base    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_LANG_MODE:  r_mode       <= i_cfg_data[1:0];
                REG_ASCII_BASE: r_ascii_base <= i_cfg_data;
                REG_JP_BASE:    r_jp_base    <= i_cfg_data;
                REG_CN_BASE:    r_cn_base    <= i_cfg_data;
                default:        r_mode       <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_sx   <= s_axis_tdata[11:0];
            r_in_byte <= s_axis_tdata[19:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= 8'd0;
            r_cursor <= '0;
        end else if (proc) begin
            r_lead   <= dec.lead;
            r_cursor <= dec_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && dec.num != 2'd0) begin
            r_q[r_wr_ptr] <= dec.res0;
        end
        if (proc && dec.num == 2'd2) begin
            r_q[PW'(r_wr_ptr + PW'(1))] <= dec.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= PW'(r_wr_ptr + wr_num[PW-1:0]);
            r_rd_ptr <= PW'(r_rd_ptr + PW'(pop));
            r_cnt    <= n_cnt;
        end
    end

    assign head          = r_q[r_rd_ptr];
    assign m_axis_tvalid = r_cnt != '0;
    assign m_axis_tdata  = {3'd0, head.dx, head.addr};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multibyte text glyph decoder core. Directed
// bytes cover ASCII, Shift-JIS, EUC-JP and GB2312 edge cases, then random
// text streams run under each mode with random and long output stalls.
// A scoreboard predicts each glyph command and checks them in order.
// ----------------------------------------------------------------------------
module tb;
    import mtgd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG   = 4000;
    localparam int SETTLE     = 8;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_PHASE = 80;

    class glyph_scoreboard;
        logic [1:0]  mode       = MODE_ASCII;
        logic [31:0] ascii_base = '0;
        logic [31:0] jp_base    = '0;
        logic [31:0] cn_base    = '0;
        logic [7:0]  lead       = '0;
        logic [11:0] cursor     = '0;
        t_result     expected_cmds[$];
        int          errors     = 0;
        int          n_bytes    = 0;
        int          n_begins   = 0;
        int          n_trails   = 0;
        int          n_cmds     = 0;

        static function logic is_lead(logic [1:0] m, logic [7:0] b);
            case (m)
                MODE_SJIS:  return (b >= SJ_LEAD1_LO && b <= SJ_LEAD1_HI) ||
                                   (b >= SJ_LEAD2_LO && b <= SJ_LEAD2_HI);
                MODE_EUCJP: return b >= EUC_LEAD_LO && b <= EUC_LEAD_HI;
                MODE_GB:    return b >= ROW_LO && b <= ROW_HI;
                default:    return 1'b0;
            endcase
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_LANG_MODE:  mode       = val[1:0];
                REG_ASCII_BASE: ascii_base = val;
                REG_JP_BASE:    jp_base    = val;
                REG_CN_BASE:    cn_base    = val;
            endcase
        endfunction

        function void push(logic [31:0] addr, logic [12:0] dx, logic [1:0] kind,
                           logic last);
            t_result r;
            r.addr = addr;
            r.dx   = dx;
            r.kind = kind;
            r.last = last;
            expected_cmds.push_back(r);
        endfunction

        function void decode_item(logic cmd, logic [11:0] sx, logic [7:0] b);
            logic [31:0] k, t, idx, addr;
            logic [11:0] cur;
            cur = cursor;
            if (cmd == CMD_BEGIN) begin
                cursor = sx;
                n_begins++;
                return;
            end
            n_bytes++;
            if (mode == MODE_ASCII) begin
                push(ascii_base + 32'(b) * 16, 13'(cur), KIND_SINGLE, 1'b1);
            end else if (lead == 8'h00) begin
                if (is_lead(mode, b))
                    lead = b;
                else
                    push(((mode == MODE_GB) ? ascii_base : jp_base) + 32'(b) * 16,
                         13'(cur), KIND_SINGLE, 1'b1);
            end else begin
                if (mode == MODE_SJIS) begin
                    if (lead >= SJ_LEAD1_LO && lead <= SJ_LEAD1_HI)
                        k = (32'(lead) - 32'(SJ_LEAD1_LO)) * 2;
                    else
                        k = (32'(lead) - 32'(SJ_LEAD2_LO)) * 2 + SJ_ROW_OFFSET;
                    if (b >= SJ_TRAIL1_LO && b <= SJ_TRAIL1_HI) begin
                        t = 32'(b) - 32'(SJ_TRAIL1_LO);
                    end else if (b >= SJ_TRAIL2_LO && b <= SJ_TRAIL2_HI) begin
                        t = 32'(b) - 32'(SJ_TRAIL2_LO) + SJ_TRAIL2_ADD;
                    end else begin
                        t = 32'(b) - 32'(SJ_TRAIL3_LO);
                        k = k + 1;
                    end
                end else begin
                    k = 32'(lead) - 32'(ROW_LO);
                    t = 32'(b) - 32'(ROW_LO);
                end
                lead = 8'h00;
                n_trails++;
                idx = k * ROW_CELLS + t;
                if (mode == MODE_GB) begin
                    push(cn_base + idx * 32, 13'(cur) - 13'd8, KIND_MIRROR, 1'b1);
                end else begin
                    addr = jp_base + JP_FULL_OFFSET + idx * 32;
                    push(addr, 13'(cur) - 13'd8, KIND_LEFT, 1'b0);
                    push(addr + HALF_STEP, 13'(cur), KIND_RIGHT, 1'b1);
                end
            end
            cursor = cur + 12'd8;
        endfunction

        function void check_cmd(t_result got);
            t_result want;
            if (expected_cmds.size() == 0) begin
                $display("%0t: unexpected command: addr=%h dx=%0d kind=%0d last=%0d",
                         $time, got.addr, $signed(got.dx), got.kind, got.last);
                errors++;
                return;
            end
            want = expected_cmds.pop_front();
            n_cmds++;
            if (got.addr !== want.addr) begin
                $display("%0t: glyph_addr expected %h actual %h", $time, want.addr,
                         got.addr);
                errors++;
            end
            if (got.dx !== want.dx) begin
                $display("%0t: draw_x expected %0d actual %0d", $time,
                         $signed(want.dx), $signed(got.dx));
                errors++;
            end
            if (got.kind !== want.kind) begin
                $display("%0t: glyph_kind expected %0d actual %0d", $time, want.kind,
                         got.kind);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last,
                         got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = CMD_BEGIN;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr    = '0;
    logic [31:0] i_cfg_data    = '0;

    glyph_scoreboard sb = new();

    int send_idle     = 0;
    int recv_idle     = 0;
    int hold_cnt      = 0;
    bit long_hold_req = 1'b0;
    int quiet         = 0;
    int n_configs     = 0;

    multibyte_text_glyph_decoder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output side: check each accepted command, then pick next tready
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.addr = m_axis_tdata[31:0];
            got.dx   = m_axis_tdata[44:32];
            got.kind = m_axis_tuser;
            got.last = m_axis_tlast;
            sb.check_cmd(got);
        end
        if (long_hold_req && hold_cnt == 0) begin
            hold_cnt      = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_item(input logic cmd, input logic [11:0] sx, input logic [7:0] b);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'h0, b, sx};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.decode_item(cmd, sx, b);
    endtask

    task automatic text(input logic [7:0] b);
        send_item(CMD_BYTE, 12'($urandom), b);
    endtask

    task automatic begin_at(input logic [11:0] x);
        send_item(CMD_BEGIN, x, 8'($urandom));
    endtask

    // lead bytes and begins give no command, so allow the pipeline to drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [1:0] m, input logic [31:0] a,
                               input logic [31:0] j, input logic [31:0] c);
        write_reg(REG_LANG_MODE, 32'(m));
        write_reg(REG_ASCII_BASE, a);
        write_reg(REG_JP_BASE, j);
        write_reg(REG_CN_BASE, c);
        n_configs++;
    endtask

    function automatic logic [31:0] pick_base();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return 32'($urandom);
        endcase
    endfunction

    // mostly well-formed singles and lead/trail pairs, some begins and noise
    task automatic run_random(input logic [1:0] m, input int n_items);
        int         sent;
        int         r;
        logic [7:0] b;
        logic [11:0] x;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 6) begin
                case ($urandom_range(3))
                    0:       x = 12'h000;
                    1:       x = 12'hFFF;
                    2:       x = 12'hFF8;
                    default: x = 12'($urandom);
                endcase
                begin_at(x);
                sent++;
            end else if (r < 14 || m == MODE_ASCII) begin
                text(8'($urandom));
                sent++;
            end else if (r < 45) begin
                do b = 8'($urandom); while (glyph_scoreboard::is_lead(m, b));
                text(b);
                sent++;
            end else begin
                if (m == MODE_SJIS)
                    b = $urandom_range(1) ? 8'($urandom_range(SJ_LEAD1_LO, SJ_LEAD1_HI))
                                          : 8'($urandom_range(SJ_LEAD2_LO, SJ_LEAD2_HI));
                else
                    b = 8'($urandom_range(ROW_LO, ROW_HI));
                text(b);
                if (m == MODE_SJIS)
                    b = $urandom_range(1) ? 8'($urandom_range(SJ_TRAIL1_LO, SJ_TRAIL1_HI))
                                          : 8'($urandom_range(SJ_TRAIL2_LO, 8'hfc));
                else
                    b = 8'($urandom_range(ROW_LO, ROW_HI));
                text(b);
                sent += 2;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 25;
        recv_idle = 48;

        // ascii: address wrap, cursor wrap past 4095
        load_config(MODE_ASCII, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        begin_at(12'hFFF);
        text(8'h00);
        text(8'hFF);
        text(8'h81);
        settle();

        // shift-jis: both lead ranges, all trail ranges, left half at column -8,
        // begin between lead and trail keeps the lead
        load_config(MODE_SJIS, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        begin_at(12'hFF8);
        text(8'h81);
        text(8'h40);
        text(8'h9f);
        begin_at(12'd100);
        text(8'h7e);
        text(8'he0);
        text(8'h80);
        text(8'hfc);
        text(8'hfc);
        text(8'h41);
        text(8'ha0);
        settle();

        // euc-jp: top lead, malformed trail, low lead with negative row
        load_config(MODE_EUCJP, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF);
        text(8'hfe);
        text(8'ha1);
        text(8'h81);
        text(8'h00);
        text(8'hff);
        settle();

        // gb2312, then a lead left pending across mode changes
        load_config(MODE_GB, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        text(8'ha1);
        text(8'hfe);
        text(8'hfe);
        text(8'h20);
        text(8'h41);
        text(8'ha1);
        settle();
        write_reg(REG_LANG_MODE, 32'(MODE_ASCII));
        text(8'h41);
        settle();
        write_reg(REG_LANG_MODE, 32'(MODE_SJIS));
        text(8'h20);
        settle();

        for (int p = 0; p < 9; p++) begin
            if (p < 3) begin
                send_idle = 25;
                recv_idle = 48;
            end else if (p < 6) begin
                send_idle = 48;
                recv_idle = 25;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            load_config(2'(p % 4), pick_base(), pick_base(), pick_base());
            if (p == 6)
                long_hold_req = 1'b1;
            run_random(2'(p % 4), RAND_PHASE);
            settle();
        end

        $display("Sent %0d text bytes and %0d begins over %0d configurations,",
                 sb.n_bytes, sb.n_begins, n_configs);
        $display("decoding %0d multibyte characters; %0d glyph commands checked.",
                 sb.n_trails, sb.n_cmds);
        if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/mtgd_pkg.sv
sv/mtgd_decode.sv
sv/multibyte_text_glyph_decoder_core.sv
dv/tb.sv
